[rtl/core/rgbcm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rgbcm_pkg;

    // Fixed field widths
    localparam int PIX_W       = 8;
    localparam int COMP_W      = 16;
    localparam int INDEX_W     = 15;

    // Cube geometry: 32 points per axis, 8 pixel steps per cell
    localparam int CUBE_BITS   = 5;
    localparam int CUBE_SIDE   = 1 << CUBE_BITS;
    localparam int CUBE_DEPTH  = CUBE_SIDE * CUBE_SIDE * CUBE_SIDE;
    localparam int CELL_SHIFT  = 3;
    localparam int CELL_STEPS  = 1 << CELL_SHIFT;
    localparam int TOP_BASE    = CUBE_SIDE - 2;
    localparam int FULL_SCALE  = 255;

    localparam int FRACTION_BITS_DEFAULT = 15;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef struct packed {
        op_t                opcode;
        logic [INDEX_W-1:0] entry_index;
        logic [COMP_W-1:0]  entry_red;
        logic [COMP_W-1:0]  entry_green;
        logic [COMP_W-1:0]  entry_blue;
        logic [PIX_W-1:0]   pixel_red;
        logic [PIX_W-1:0]   pixel_green;
        logic [PIX_W-1:0]   pixel_blue;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
    } out_item_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } entry_t;

    // Load strobes for the blend stages
    typedef struct packed {
        logic load2;
        logic load3;
        logic load4;
    } pipe_en_t;

endpackage

`default_nettype wire

[rtl/core/rgbcm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module rgbcm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/rgbcm_blend.sv]
`timescale 1ns / 1ps
`default_nettype none

// One channel: weighted sum, scale by 255, shift, saturate or bypass.
module rgbcm_blend #(
    parameter int FRACTION_BITS = rgbcm_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire rgbcm_pkg::pipe_en_t              en,
    input  wire logic                             bypass,
    input  wire logic [rgbcm_pkg::PIX_W-1:0]      pixel,
    input  wire logic [rgbcm_pkg::COMP_W-1:0]     base_comp,
    input  wire logic [rgbcm_pkg::COMP_W-1:0]     diag_comp,
    output logic      [rgbcm_pkg::PIX_W-1:0]      result
);

    localparam int PW     = rgbcm_pkg::PIX_W;
    localparam int CS     = rgbcm_pkg::CELL_SHIFT;
    localparam int ACC_W  = rgbcm_pkg::COMP_W + CS;
    localparam int PROD_W = ACC_W + PW;
    localparam int SHIFT  = FRACTION_BITS + CS;

    logic [CS-1:0]     frac;
    logic [CS:0]       w_base;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [PW-1:0]     pix2_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PW-1:0]     pix3_reg;
    logic [PROD_W-1:0] scaled;
    logic [PW-1:0]     sat;
    logic [PW-1:0]     result_next;
    logic [PW-1:0]     result_reg;

    assign frac     = pixel[CS-1:0];
    assign w_base   = (CS+1)'(rgbcm_pkg::CELL_STEPS) - {1'b0, frac};
    assign acc_next = ACC_W'(w_base) * ACC_W'(base_comp)
                    + ACC_W'(frac) * ACC_W'(diag_comp);

    assign prod_next = PROD_W'(acc_reg) * PROD_W'(rgbcm_pkg::FULL_SCALE);

    assign scaled      = prod_reg >> SHIFT;
    assign sat         = (|scaled[PROD_W-1:PW]) ? {PW{1'b1}} : scaled[PW-1:0];
    assign result_next = bypass ? pix3_reg : sat;

    always_ff @(posedge aclk) begin
        if (en.load2) begin
            acc_reg  <= acc_next;
            pix2_reg <= pixel;
        end
        if (en.load3) begin
            prod_reg <= prod_next;
            pix3_reg <= pix2_reg;
        end
        if (en.load4) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/core/rgb_cube_lut_color_map.sv]
`timescale 1ns / 1ps
`default_nettype none

// RGB cube color map. A beat on the s_ channel either writes one entry of the
// 32x32x32 cube (opcode write: entry_index = red + 32*green + 1024*blue, three
// unsigned components where 2^FRACTION_BITS means 1.0) or maps one pixel
// (opcode pixel). Each pixel channel selects base point value/8 (31 clamps to
// 30) and blends the base entry with the entry one step along the main
// diagonal by (value mod 8)/8, scales by 255, truncates and saturates to
// 0..255. With table_enable low the pixel comes back unchanged. A write beat
// gives no result; a pixel beat gives exactly one m_ beat. The block takes one
// beat per clock while s_ready is high. A pixel passes the table read, the
// weighted sum, the multiply by 255, and the shift/saturate output register
// on its way to m_valid. Each stage holds on its own when the next one is
// full, so a stalled m_ side still lets bubbles fill. The table is held
// twice, once for each of the two entries read per pixel, with every write
// going to both. The table is not cleared at reset: map only pixels whose
// entries were written. Write table_enable only while no pixel is in flight.
module rgb_cube_lut_color_map #(
    parameter int FRACTION_BITS = rgbcm_pkg::FRACTION_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rgbcm_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output rgbcm_pkg::out_item_t      m_data
);

    localparam int CB    = rgbcm_pkg::CUBE_BITS;
    localparam int PW    = rgbcm_pkg::PIX_W;
    localparam int CS    = rgbcm_pkg::CELL_SHIFT;
    localparam int DEPTH = rgbcm_pkg::CUBE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $bits(rgbcm_pkg::entry_t);

    logic              table_enable_reg;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              load1, load2, load3, load4;
    rgbcm_pkg::pipe_en_t en;
    logic              accept, wr_en, rd_en;
    logic [CB-1:0]     base_r, base_g, base_b;
    logic [AW-1:0]     addr_base, addr_diag;
    rgbcm_pkg::entry_t wr_entry, base_entry, diag_entry;
    logic [EW-1:0]     base_word, diag_word;
    logic [PW-1:0]     pix_r1_reg, pix_g1_reg, pix_b1_reg;

    // Stage loads: a stage advances when empty or when its successor advances
    assign load4 = !v4_reg || m_ready;
    assign load3 = !v3_reg || load4;
    assign load2 = !v2_reg || load3;
    assign load1 = !v1_reg || load2;

    assign en.load2 = load2;
    assign en.load3 = load3;
    assign en.load4 = load4;

    assign s_ready = load1;
    assign accept  = s_valid && s_ready;
    assign wr_en   = accept && (s_data.opcode == rgbcm_pkg::OP_WRITE);
    assign rd_en   = accept && (s_data.opcode == rgbcm_pkg::OP_PIXEL);

    // Base cube point per channel; the top cell folds into the one below
    function automatic logic [CB-1:0] cube_base(input logic [PW-1:0] v);
        logic [CB-1:0] b;
        b = v[PW-1:CS];
        return (b > CB'(rgbcm_pkg::TOP_BASE)) ? CB'(rgbcm_pkg::TOP_BASE) : b;
    endfunction

    assign base_r = cube_base(s_data.pixel_red);
    assign base_g = cube_base(s_data.pixel_green);
    assign base_b = cube_base(s_data.pixel_blue);

    // Bases stop at 30, so +1 per axis never carries across fields
    assign addr_base = {base_b, base_g, base_r};
    assign addr_diag = {base_b + CB'(1), base_g + CB'(1), base_r + CB'(1)};

    assign wr_entry.red   = s_data.entry_red;
    assign wr_entry.green = s_data.entry_green;
    assign wr_entry.blue  = s_data.entry_blue;

    rgbcm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_base (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_data.entry_index),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (addr_base),
        .rd_data (base_word)
    );

    rgbcm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_diag (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_data.entry_index),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (addr_diag),
        .rd_data (diag_word)
    );

    assign base_entry = base_word;
    assign diag_entry = diag_word;

    // Config register and valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_enable_reg <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                table_enable_reg <= cfg_wr_data;
            end
            if (load1) begin
                v1_reg <= rd_en;
            end
            if (load2) begin
                v2_reg <= v1_reg;
            end
            if (load3) begin
                v3_reg <= v2_reg;
            end
            if (load4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Pixel rides alongside the table read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            pix_r1_reg <= s_data.pixel_red;
            pix_g1_reg <= s_data.pixel_green;
            pix_b1_reg <= s_data.pixel_blue;
        end
    end

    rgbcm_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend_red (
        .aclk      (aclk),
        .en        (en),
        .bypass    (!table_enable_reg),
        .pixel     (pix_r1_reg),
        .base_comp (base_entry.red),
        .diag_comp (diag_entry.red),
        .result    (m_data.out_red)
    );

    rgbcm_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend_green (
        .aclk      (aclk),
        .en        (en),
        .bypass    (!table_enable_reg),
        .pixel     (pix_g1_reg),
        .base_comp (base_entry.green),
        .diag_comp (diag_entry.green),
        .result    (m_data.out_green)
    );

    rgbcm_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend_blue (
        .aclk      (aclk),
        .en        (en),
        .bypass    (!table_enable_reg),
        .pixel     (pix_b1_reg),
        .base_comp (base_entry.blue),
        .diag_comp (diag_entry.blue),
        .result    (m_data.out_blue)
    );

    assign m_valid = v4_reg;

    // A write beat leaves a bubble in the read stage
    a_write_no_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.opcode == rgbcm_pkg::OP_WRITE) |=> !v1_reg)
        else $error("write beat entered the result pipeline");

    // A pixel beat always occupies the read stage next cycle
    a_pixel_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.opcode == rgbcm_pkg::OP_PIXEL) |=> v1_reg)
        else $error("pixel beat lost at the read stage");

    // A full middle stage blocked downstream keeps its item
    a_stage3_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !load4) |=> v3_reg)
        else $error("stalled blend stage dropped its item");

    // Reset empties the output
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

[tb/sv/rgb_cube_lut_color_map_tb.sv]
`timescale 1ns / 1ps

module rgb_cube_lut_color_map_tb;

    localparam int PIX_W         = rgbcm_pkg::PIX_W;
    localparam int COMP_W        = rgbcm_pkg::COMP_W;
    localparam int INDEX_W       = rgbcm_pkg::INDEX_W;
    localparam int CELL_SHIFT    = rgbcm_pkg::CELL_SHIFT;
    localparam int CELL_STEPS    = rgbcm_pkg::CELL_STEPS;
    localparam int CUBE_SIDE     = rgbcm_pkg::CUBE_SIDE;
    localparam int CUBE_DEPTH    = rgbcm_pkg::CUBE_DEPTH;
    localparam int TOP_BASE      = rgbcm_pkg::TOP_BASE;
    localparam int FULL_SCALE    = rgbcm_pkg::FULL_SCALE;

    localparam int FRACTION_BITS = rgbcm_pkg::FRACTION_BITS_DEFAULT;
    // One step along the main diagonal: +1 in red, green and blue
    localparam int DIAG_STEP     = 1 + CUBE_SIDE + CUBE_SIDE * CUBE_SIDE;
    // Four pipeline stages plus margin; used once every expected result is back
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int PHASES        = 6;
    localparam int CYCLE_LIMIT   = 1000000;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    rgbcm_pkg::in_item_t  s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    rgbcm_pkg::out_item_t m_data;

    // Shadow of the cube and of the enable register, plus a map of the
    // entries that have been loaded so no pixel ever reads an unwritten one
    rgbcm_pkg::entry_t    cube_mirror  [CUBE_DEPTH];
    bit                   entry_loaded [CUBE_DEPTH];
    bit                   table_on     = 1'b0;

    rgbcm_pkg::out_item_t pending_pixels[$];

    // Idle controls: steady means no gaps on that side
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;
    int        stall_left = 0;

    int        cycle_count = 0;
    int        n_fail      = 0;
    int        n_items     = 0;
    int        n_writes    = 0;
    int        n_pixels    = 0;
    int        n_mapped    = 0;
    int        n_results   = 0;
    int        n_cfg       = 0;

    rgb_cube_lut_color_map #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #10 aclk = ~aclk;

    // Hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results still expected",
                   cycle_count, pending_pixels.size());
            $display("** rgb_cube_lut_color_map: FAILED **");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Component value: mostly within 0..1.0, with the endpoints and values
    // above one mixed in so the saturation path gets exercised
    function automatic logic [COMP_W-1:0] rand_comp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return COMP_W'($urandom_range(0, 1 << FRACTION_BITS));
        else if (r < 68)
            return '0;
        else if (r < 80)
            return COMP_W'(1 << FRACTION_BITS);
        else if (r < 88)
            return '1;
        return COMP_W'($urandom);
    endfunction

    // Pixel channel: mostly uniform, sometimes a cell edge or the clamp region
    function automatic logic [PIX_W-1:0] pick_chan();
        logic [PIX_W-1:0] edges [6];
        edges = '{8'd0, 8'd7, 8'd8, 8'd247, 8'd248, 8'd255};
        if ($urandom_range(0, 99) < 70)
            return PIX_W'($urandom);
        return edges[$urandom_range(0, 5)];
    endfunction

    // Every field random but the opcode (a write); callers set the opcode and whatever matters
    function automatic rgbcm_pkg::in_item_t noise_item();
        rgbcm_pkg::in_item_t it;
        it.opcode      = rgbcm_pkg::OP_WRITE;
        it.entry_index = INDEX_W'($urandom);
        it.entry_red   = COMP_W'($urandom);
        it.entry_green = COMP_W'($urandom);
        it.entry_blue  = COMP_W'($urandom);
        it.pixel_red   = PIX_W'($urandom);
        it.pixel_green = PIX_W'($urandom);
        it.pixel_blue  = PIX_W'($urandom);
        return it;
    endfunction

    // Base corner of the cell a pixel falls in; the top cell clamps to 30
    function automatic logic [INDEX_W-1:0] cube_addr(input logic [PIX_W-1:0] r,
                                                     input logic [PIX_W-1:0] g,
                                                     input logic [PIX_W-1:0] b);
        int br;
        int bg;
        int bb;
        br = r >> CELL_SHIFT;
        bg = g >> CELL_SHIFT;
        bb = b >> CELL_SHIFT;
        if (br > TOP_BASE) br = TOP_BASE;
        if (bg > TOP_BASE) bg = TOP_BASE;
        if (bb > TOP_BASE) bb = TOP_BASE;
        return INDEX_W'(br + CUBE_SIDE * bg + CUBE_SIDE * CUBE_SIDE * bb);
    endfunction

    // Linear blend of two components, scaled to 0..255, truncated, saturated
    function automatic logic [PIX_W-1:0] blend(input logic [COMP_W-1:0] lo,
                                               input logic [COMP_W-1:0] hi,
                                               input logic [CELL_SHIFT-1:0] f);
        longint unsigned acc;
        acc = (64'(CELL_STEPS) - 64'(f)) * 64'(lo) + 64'(f) * 64'(hi);
        acc = (acc * 64'(FULL_SCALE)) >> (FRACTION_BITS + CELL_SHIFT);
        if (acc > 64'(FULL_SCALE))
            return PIX_W'(FULL_SCALE);
        return acc[PIX_W-1:0];
    endfunction

    // Expected output for one pixel given the current shadow state
    function automatic rgbcm_pkg::out_item_t map_pixel(input logic [PIX_W-1:0] r,
                                                       input logic [PIX_W-1:0] g,
                                                       input logic [PIX_W-1:0] b);
        rgbcm_pkg::out_item_t o;
        logic [INDEX_W-1:0]   a0;
        rgbcm_pkg::entry_t    lo;
        rgbcm_pkg::entry_t    hi;
        if (!table_on) begin
            o.out_red   = r;
            o.out_green = g;
            o.out_blue  = b;
            return o;
        end
        a0 = cube_addr(r, g, b);
        lo = cube_mirror[a0];
        hi = cube_mirror[a0 + INDEX_W'(DIAG_STEP)];
        o.out_red   = blend(lo.red,   hi.red,   r[CELL_SHIFT-1:0]);
        o.out_green = blend(lo.green, hi.green, g[CELL_SHIFT-1:0]);
        o.out_blue  = blend(lo.blue,  hi.blue,  b[CELL_SHIFT-1:0]);
        return o;
    endfunction

    // Send one beat: idle for a random gap, present it, hold until accepted,
    // then update the shadow state or queue the expected pixel. Call right
    // after a rising edge; returns right after the accepting edge.
    task automatic send_beat(input rgbcm_pkg::in_item_t it);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        n_items++;
        if (it.opcode == rgbcm_pkg::OP_WRITE) begin
            cube_mirror[it.entry_index]  = '{red: it.entry_red, green: it.entry_green,
                                             blue: it.entry_blue};
            entry_loaded[it.entry_index] = 1'b1;
            n_writes++;
        end else begin
            pending_pixels.push_back(map_pixel(it.pixel_red, it.pixel_green,
                                               it.pixel_blue));
            n_pixels++;
            if (table_on)
                n_mapped++;
        end
    endtask

    task automatic send_write(input logic [INDEX_W-1:0] idx,
                              input logic [COMP_W-1:0]  r,
                              input logic [COMP_W-1:0]  g,
                              input logic [COMP_W-1:0]  b);
        rgbcm_pkg::in_item_t it;
        it             = noise_item();
        it.opcode      = rgbcm_pkg::OP_WRITE;
        it.entry_index = idx;
        it.entry_red   = r;
        it.entry_green = g;
        it.entry_blue  = b;
        send_beat(it);
    endtask

    // Map one pixel; load either of its two entries first if still unwritten
    task automatic send_pixel(input logic [PIX_W-1:0] r,
                              input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        rgbcm_pkg::in_item_t it;
        logic [INDEX_W-1:0]  a0;
        logic [INDEX_W-1:0]  a1;
        a0 = cube_addr(r, g, b);
        a1 = a0 + INDEX_W'(DIAG_STEP);
        if (!entry_loaded[a0])
            send_write(a0, rand_comp(), rand_comp(), rand_comp());
        if (!entry_loaded[a1])
            send_write(a1, rand_comp(), rand_comp(), rand_comp());
        it             = noise_item();
        it.opcode      = rgbcm_pkg::OP_PIXEL;
        it.pixel_red   = r;
        it.pixel_green = g;
        it.pixel_blue  = b;
        send_beat(it);
    endtask

    // Drop valid, hold until every expected result is back, then let the
    // pipeline finish any trailing write
    task automatic drain_pipe();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write, only with the block idle
    task automatic set_enable(input bit on);
        drain_pipe();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        table_on     = on;
        n_cfg++;
        @(posedge aclk);
    endtask

    // Result side: check each accepted beat against the oldest expectation,
    // then pick m_ready for the next cycle
    always @(posedge aclk) begin
        rgbcm_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("result with nothing expected: %h", m_data);
                n_fail++;
            end else begin
                want = pending_pixels.pop_front();
                n_results++;
                if (m_data.out_red !== want.out_red) begin
                    $error("out_red: expected %0d, got %0d", want.out_red, m_data.out_red);
                    n_fail++;
                end
                if (m_data.out_green !== want.out_green) begin
                    $error("out_green: expected %0d, got %0d",
                           want.out_green, m_data.out_green);
                    n_fail++;
                end
                if (m_data.out_blue !== want.out_blue) begin
                    $error("out_blue: expected %0d, got %0d",
                           want.out_blue, m_data.out_blue);
                    n_fail++;
                end
            end
        end
        if (rx_steady) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 25) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready    <= 1'b1;
        end
    end

    // Table off after reset: pixels come back unchanged, writes still land
    task automatic test_passthrough();
        send_write(INDEX_W'(0),     16'h0000, 16'h8000, 16'hFFFF);
        send_write(INDEX_W'(DIAG_STEP), 16'hFFFF, 16'h0000, 16'h8000);
        send_write(INDEX_W'(CUBE_DEPTH - 1 - DIAG_STEP), 16'h8000, 16'h4000, 16'h0000);
        send_write(INDEX_W'(CUBE_DEPTH - 1), 16'h0000, 16'hFFFF, 16'h8000);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'hA5,  8'h5A,  8'h0F);
    endtask

    // Table on: cell corners, the clamped top cell, seven-eighths weight on the far
    // entry, saturation above one, and exact 1.0
    task automatic test_enabled_corners();
        set_enable(1'b1);
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd7,   8'd7,   8'd7);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd248, 8'd248, 8'd248);
        send_pixel(8'd247, 8'd240, 8'd255);
        send_pixel(8'd8,   8'd16,  8'd24);
        send_pixel(8'd0,   8'd255, 8'd128);
        send_pixel(8'd3,   8'd4,   8'd5);
        // rewrite an entry and read it back right away
        send_write(INDEX_W'(0), 16'hFFFF, 16'h8000, 16'h0001);
        send_pixel(8'd1, 8'd2, 8'd6);
    endtask

    // Random traffic in phases; the enable changes between phases with the
    // pipeline drained, one phase runs with no idling at all
    task automatic test_random_traffic();
        int stop_at;
        int p;
        int r;
        rgbcm_pkg::in_item_t it;
        for (p = 0; p < PHASES; p++) begin
            if (p == 0)
                set_enable(1'b1);
            else if (p == 1)
                set_enable(1'b0);
            else
                set_enable(1'($urandom_range(0, 1)));
            tx_steady = (p == 3);
            rx_steady = (p == 3);
            stop_at   = n_items + RANDOM_ITEMS / PHASES;
            while (n_items < stop_at) begin
                r = $urandom_range(0, 99);
                if (r < 62) begin
                    send_pixel(pick_chan(), pick_chan(), pick_chan());
                end else if (r < 90) begin
                    send_write(INDEX_W'($urandom), rand_comp(), rand_comp(), rand_comp());
                end else begin
                    // raw noise write, every field unconstrained
                    it = noise_item();
                    send_beat(it);
                end
                // pause the sender until the result side catches up
                if ((p == 2 && n_items == stop_at - 100) || $urandom_range(0, 299) == 0)
                    drain_pipe();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        foreach (entry_loaded[i])
            entry_loaded[i] = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_enabled_corners();
        test_random_traffic();

        drain_pipe();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d beats: %0d table writes, %0d pixels (%0d through the table).",
                 n_items, n_writes, n_pixels, n_mapped);
        $display("Checked %0d results across %0d enable writes in %0d cycles.",
                 n_results, n_cfg, cycle_count);
        if (n_fail == 0)
            $display("** rgb_cube_lut_color_map: PASSED **");
        else
            $display("** rgb_cube_lut_color_map: FAILED **");
        $finish;
    end

endmodule

[rgb_cube_lut_color_map.f]
rtl/core/rgbcm_pkg.sv
rtl/core/rgbcm_ram.sv
rtl/core/rgbcm_blend.sv
rtl/core/rgb_cube_lut_color_map.sv
tb/sv/rgb_cube_lut_color_map_tb.sv
